// ===== design/mipmap_wavetable_interp_lookup_assert.svh =====
// assertion macros for the wavetable lookup block
`ifndef MIPMAP_WAVETABLE_INTERP_LOOKUP_ASSERT_SVH
`define MIPMAP_WAVETABLE_INTERP_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define MWL_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MWL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define MWL_ASSERT_IMPL(label, clk, rst_n, prop)
`define MWL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== design/mwl_pkg.sv =====
// shared constants, types and helpers for the wavetable lookup block
package mwl_pkg;
    localparam int TableSize   = 4096;
    localparam int MorphSteps  = 256;
    localparam int DutySteps   = 16;
    localparam int MipLevels   = 8;
    localparam int PulseMorph  = MorphSteps / 16;
    localparam int PulseTables = PulseMorph * DutySteps;
    localparam int IdxW   = $clog2(TableSize);
    localparam int LvlW   = 3;
    localparam int SawTW  = $clog2(MorphSteps);
    localparam int PulTW  = $clog2(PulseTables);
    localparam int PmW    = $clog2(PulseMorph);
    localparam int DsW    = $clog2(DutySteps);
    localparam int SawAW  = LvlW + SawTW + IdxW - 1;
    localparam int PulAW  = LvlW + PulTW + IdxW - 1;
    localparam int SmpW   = 18;

    typedef enum logic [1:0] {
        MODE_LOAD_SAW   = 2'd0,
        MODE_LOAD_PULSE = 2'd1,
        MODE_SAW        = 2'd2,
        MODE_PULSE      = 2'd3
    } t_mode;

    // truncating lerp, floor division by 65536
    function automatic logic signed [SmpW-1:0] lerp(input logic signed [SmpW-1:0] a,
            input logic signed [SmpW-1:0] b, input logic [15:0] f);
        logic signed [SmpW:0]    d;
        logic signed [SmpW+17:0] p;
        logic signed [SmpW+1:0]  s;
        d = {b[SmpW-1], b} - {a[SmpW-1], a};
        p = d * $signed({1'b0, f});
        s = {{2{a[SmpW-1]}}, a} + p[SmpW+17:16];
        return s[SmpW-1:0];
    endfunction

    function automatic logic [LvlW-1:0] pick_level(input logic [15:0] f);
        logic [LvlW-1:0] l;
        l = '0;
        for (int k = 0; k < MipLevels - 1; k++) begin
            if (32'(f) >= (32'd6000 << k)) l = LvlW'(k + 1);
        end
        return l;
    endfunction
endpackage

// ===== design/mipmap_wavetable_interp_lookup.sv =====
// mipmapped saw/pulse wavetable store with bilinear interpolated lookup
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  item     | in        | i_start / o_busy   | mode, phase, morph, duty, freq, load
//  result   | out       | o_valid strobe     | o_sample_out
//  config   | in        | i_cfg_we           | i_cfg_wdata (tables_ready)
//
// one item per cycle; o_busy is always low. a lookup passes through the
// address stage, memory read stage, phase lerp, duty lerp, then morph lerp
// and output register. each store is split into even and odd sample banks,
// and each corner table has its own bank set, so every corner pair is read
// in parallel. a load writes the matching bank copies in its read stage;
// loads and lookups in flight never address conflicting data under the
// idle-before-config rule, loads precede lookups in program order through
// the ordered write-then-read of the same pipeline stage.
// synchronous active-low reset clears control only; stores are not cleared.
module mipmap_wavetable_interp_lookup
    import mwl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic [1:0]             i_mode,
    input  logic [31:0]            i_phase,
    input  logic [16:0]            i_morph,
    input  logic [16:0]            i_duty,
    input  logic [15:0]            i_frequency_hz,
    input  logic [2:0]             i_table_level,
    input  logic [7:0]             i_table_number,
    input  logic [11:0]            i_sample_index,
    input  logic signed [17:0]     i_sample_value,
    output logic                   o_valid,
    output logic signed [17:0]     o_sample_out
);
    `include "mipmap_wavetable_interp_lookup_assert.svh"

    localparam int SawD = 1 << SawAW;
    localparam int PulD = 1 << PulAW;

    // even/odd banks, two copies each so two corners read in parallel (saw)
    logic signed [SmpW-1:0] saw_e0 [SawD], saw_o0 [SawD], saw_e1 [SawD], saw_o1 [SawD];
    // pulse: four copies of each parity
    logic signed [SmpW-1:0] pe0 [PulD], po0 [PulD], pe1 [PulD], po1 [PulD];
    logic signed [SmpW-1:0] pe2 [PulD], po2 [PulD], pe3 [PulD], po3 [PulD];

    logic r_ready;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ready <= 1'b0;
        else if (i_cfg_we) r_ready <= i_cfg_wdata;
    end

    // ---------------- stage 0: address decode ----------------
    logic                n_lk, n_ld_saw, n_ld_pul, n_pulse, n_zero;
    logic [LvlW-1:0]     lvl;
    logic [16:0]         mpos, dpos;
    logic [SawTW+16:0]   m_sc_saw;
    logic [PmW+16:0]     m_sc_pul;
    logic [DsW+16:0]     d_sc;
    logic [SawTW-1:0]    sm0, sm1;
    logic [PmW-1:0]      pm0, pm1;
    logic [DsW-1:0]      pd0, pd1;
    logic [15:0]         mfr, dfr;
    logic [IdxW-1:0]     idx, idx1;

    always_comb begin
        mpos = i_morph > 17'd65536 ? 17'd65536 : i_morph;
        dpos = i_duty  > 17'd65536 ? 17'd65536 : i_duty;
        m_sc_saw = (SawTW+17)'(mpos) * (SawTW+17)'(MorphSteps - 1);
        m_sc_pul = (PmW+17)'(mpos) * (PmW+17)'(PulseMorph - 1);
        d_sc     = (DsW+17)'(dpos) * (DsW+17)'(DutySteps - 1);
        sm0 = m_sc_saw[SawTW+15:16];
        pm0 = m_sc_pul[PmW+15:16];
        pd0 = d_sc[DsW+15:16];
        sm1 = (32'(sm0) + 1 < MorphSteps) ? sm0 + 1'b1 : sm0;
        pm1 = (32'(pm0) + 1 < PulseMorph) ? pm0 + 1'b1 : pm0;
        pd1 = (32'(pd0) + 1 < DutySteps)  ? pd0 + 1'b1 : pd0;
        n_pulse = (t_mode'(i_mode) == MODE_PULSE);
        mfr = n_pulse ? m_sc_pul[15:0] : m_sc_saw[15:0];
        dfr = d_sc[15:0];
        lvl = pick_level(i_frequency_hz);
        idx  = i_phase[31:20];
        idx1 = idx + 1'b1;
        n_lk = i_start && (t_mode'(i_mode) == MODE_SAW || t_mode'(i_mode) == MODE_PULSE);
        n_zero = !r_ready;
        n_ld_saw = i_start && t_mode'(i_mode) == MODE_LOAD_SAW
                   && 32'(i_table_number) < MorphSteps;
        n_ld_pul = i_start && t_mode'(i_mode) == MODE_LOAD_PULSE
                   && 32'(i_table_number) < PulseTables;
    end

    // even-bank row holds index 2k, odd-bank row holds 2k+1
    function automatic logic [IdxW-2:0] erow(input logic [IdxW-1:0] a, input logic [IdxW-1:0] b);
        return a[0] ? b[IdxW-1:1] : a[IdxW-1:1];
    endfunction

    logic r1_lk, r1_pulse, r1_zero, r1_swap, r1_ld_saw, r1_ld_pul;
    logic [SawAW-1:0] r1_sa_e [2], r1_sa_o [2];
    logic [PulAW-1:0] r1_pa_e [4], r1_pa_o [4], r1_wp;
    logic [SawAW-1:0] r1_ws;
    logic r1_wodd;
    logic signed [SmpW-1:0] r1_wv;
    logic [15:0] r1_pf, r1_mf, r1_df;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_lk <= 1'b0; r1_ld_saw <= 1'b0; r1_ld_pul <= 1'b0;
        end else begin
            r1_lk <= n_lk; r1_ld_saw <= n_ld_saw; r1_ld_pul <= n_ld_pul;
        end
        r1_pulse <= n_pulse;
        r1_zero  <= n_zero;
        r1_swap  <= idx[0];
        r1_pf <= i_phase[19:4];
        r1_mf <= mfr;
        r1_df <= dfr;
        r1_sa_e[0] <= {lvl, sm0, erow(idx, idx1)};
        r1_sa_o[0] <= {lvl, sm0, idx[IdxW-1:1]};
        r1_sa_e[1] <= {lvl, sm1, erow(idx, idx1)};
        r1_sa_o[1] <= {lvl, sm1, idx[IdxW-1:1]};
        r1_pa_e[0] <= {lvl, pm0, pd0, erow(idx, idx1)};
        r1_pa_o[0] <= {lvl, pm0, pd0, idx[IdxW-1:1]};
        r1_pa_e[1] <= {lvl, pm0, pd1, erow(idx, idx1)};
        r1_pa_o[1] <= {lvl, pm0, pd1, idx[IdxW-1:1]};
        r1_pa_e[2] <= {lvl, pm1, pd0, erow(idx, idx1)};
        r1_pa_o[2] <= {lvl, pm1, pd0, idx[IdxW-1:1]};
        r1_pa_e[3] <= {lvl, pm1, pd1, erow(idx, idx1)};
        r1_pa_o[3] <= {lvl, pm1, pd1, idx[IdxW-1:1]};
        r1_ws <= {i_table_level, i_table_number[SawTW-1:0], i_sample_index[IdxW-1:1]};
        r1_wp <= {i_table_level, i_table_number[PulTW-1:0], i_sample_index[IdxW-1:1]};
        r1_wodd <= i_sample_index[0];
        r1_wv <= i_sample_value;
    end

    // ---------------- stage 1: memory write / read ----------------
    logic signed [SmpW-1:0] r2_se [2], r2_so [2], r2_pe [4], r2_po [4];

    always_ff @(posedge i_clk) begin
        if (r1_ld_saw && !r1_wodd) begin saw_e0[r1_ws] <= r1_wv; saw_e1[r1_ws] <= r1_wv; end
        if (r1_ld_saw &&  r1_wodd) begin saw_o0[r1_ws] <= r1_wv; saw_o1[r1_ws] <= r1_wv; end
        r2_se[0] <= saw_e0[r1_sa_e[0]];
        r2_so[0] <= saw_o0[r1_sa_o[0]];
        r2_se[1] <= saw_e1[r1_sa_e[1]];
        r2_so[1] <= saw_o1[r1_sa_o[1]];
    end

    always_ff @(posedge i_clk) begin
        if (r1_ld_pul && !r1_wodd) begin
            pe0[r1_wp] <= r1_wv; pe1[r1_wp] <= r1_wv; pe2[r1_wp] <= r1_wv; pe3[r1_wp] <= r1_wv;
        end
        if (r1_ld_pul && r1_wodd) begin
            po0[r1_wp] <= r1_wv; po1[r1_wp] <= r1_wv; po2[r1_wp] <= r1_wv; po3[r1_wp] <= r1_wv;
        end
        r2_pe[0] <= pe0[r1_pa_e[0]]; r2_po[0] <= po0[r1_pa_o[0]];
        r2_pe[1] <= pe1[r1_pa_e[1]]; r2_po[1] <= po1[r1_pa_o[1]];
        r2_pe[2] <= pe2[r1_pa_e[2]]; r2_po[2] <= po2[r1_pa_o[2]];
        r2_pe[3] <= pe3[r1_pa_e[3]]; r2_po[3] <= po3[r1_pa_o[3]];
    end

    logic r2_lk, r2_pulse, r2_zero, r2_swap;
    logic [15:0] r2_pf, r2_mf, r2_df;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_lk <= 1'b0;
        else r2_lk <= r1_lk;
        r2_pulse <= r1_pulse; r2_zero <= r1_zero; r2_swap <= r1_swap;
        r2_pf <= r1_pf; r2_mf <= r1_mf; r2_df <= r1_df;
    end

    // ---------------- stage 2: lerp along phase ----------------
    // odd index: first sample in odd bank, second in even bank
    logic signed [SmpW-1:0] r3_c [4];
    logic r3_lk, r3_pulse, r3_zero;
    logic [15:0] r3_mf, r3_df;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_lk <= 1'b0;
        else r3_lk <= r2_lk;
        r3_pulse <= r2_pulse; r3_zero <= r2_zero;
        r3_mf <= r2_mf; r3_df <= r2_df;
        for (int k = 0; k < 4; k++) begin
            if (r2_pulse)
                r3_c[k] <= r2_swap ? lerp(r2_po[k], r2_pe[k], r2_pf)
                                   : lerp(r2_pe[k], r2_po[k], r2_pf);
            else if (k < 2)
                r3_c[k] <= r2_swap ? lerp(r2_so[k], r2_se[k], r2_pf)
                                   : lerp(r2_se[k], r2_so[k], r2_pf);
            else
                r3_c[k] <= '0;
        end
    end

    // ---------------- stage 3: lerp along duty ----------------
    logic signed [SmpW-1:0] r4_a, r4_b;
    logic r4_lk, r4_zero;
    logic [15:0] r4_mf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_lk <= 1'b0;
        else r4_lk <= r3_lk;
        r4_zero <= r3_zero; r4_mf <= r3_mf;
        r4_a <= r3_pulse ? lerp(r3_c[0], r3_c[1], r3_df) : r3_c[0];
        r4_b <= r3_pulse ? lerp(r3_c[2], r3_c[3], r3_df) : r3_c[1];
    end

    // ---------------- stage 4: lerp along morph, output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r4_lk;
        o_sample_out <= r4_zero ? '0 : lerp(r4_a, r4_b, r4_mf);
    end

    `MWL_ASSERT_NEXT(a_lookup_strobe, i_clk, i_rst_n, r4_lk, o_valid)
    `MWL_ASSERT_NEXT(a_pipe_order, i_clk, i_rst_n, r1_lk, r2_lk)
    `MWL_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, !o_busy)
endmodule

// ===== test/mwl_lookup_checker.sv =====
// scoreboard for the wavetable lookup block: shadow stores, sample prediction, compare
`timescale 1ns / 100ps
module mwl_lookup_checker
    import mwl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_phase,
    input  logic [16:0]        i_morph,
    input  logic [16:0]        i_duty,
    input  logic [15:0]        i_frequency_hz,
    input  logic [2:0]         i_table_level,
    input  logic [7:0]         i_table_number,
    input  logic [11:0]        i_sample_index,
    input  logic signed [17:0] i_sample_value,
    input  logic               i_valid,
    input  logic signed [17:0] i_sample_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    int saw_shadow[int];
    int pulse_shadow[int];
    logic ready_shadow;
    logic signed [17:0] sample_q[$];

    function automatic int mix(int a, int b, int f);
        longint d;
        d = longint'(b - a) * f;
        return a + int'(d >>> 16);
    endfunction

    function automatic void span(logic [16:0] pos, int steps, output int lo, output int hi,
            output int f);
        longint p;
        p = (pos > 17'd65536) ? 65536 : pos;
        p = p * (steps - 1);
        lo = int'(p >> 16);
        f = int'(p & 16'hFFFF);
        hi = (lo + 1 < steps) ? lo + 1 : steps - 1;
    endfunction

    function automatic int level_of(logic [15:0] fr);
        int l;
        int thr;
        l = 0;
        thr = 6000;
        while (fr >= thr && l < MipLevels - 1) begin
            l++;
            thr = thr * 2;
        end
        return l;
    endfunction

    // phase-interpolated read of one table at the given base address
    function automatic int table_read(bit is_pulse, int base, int idx, int f);
        int a;
        int b;
        if (is_pulse) begin
            a = pulse_shadow[base + idx];
            b = pulse_shadow[base + ((idx + 1) % TableSize)];
        end else begin
            a = saw_shadow[base + idx];
            b = saw_shadow[base + ((idx + 1) % TableSize)];
        end
        return mix(a, b, f);
    endfunction

    function automatic logic signed [17:0] predict_sample(t_mode m, logic [31:0] ph,
            logic [16:0] mo, logic [16:0] du, logic [15:0] fr);
        int lvl, idx, pf, m0, m1, mf, d0, d1, df, lb, r0, r1;
        if (!ready_shadow) return '0;
        lvl = level_of(fr);
        idx = ph[31:20];
        pf = ph[19:4];
        if (m == MODE_SAW) begin
            span(mo, MorphSteps, m0, m1, mf);
            return 18'(mix(table_read(0, (lvl * MorphSteps + m0) * TableSize, idx, pf),
                           table_read(0, (lvl * MorphSteps + m1) * TableSize, idx, pf), mf));
        end
        lb = lvl * PulseTables;
        span(mo, PulseMorph, m0, m1, mf);
        span(du, DutySteps, d0, d1, df);
        r0 = mix(table_read(1, (lb + m0 * DutySteps + d0) * TableSize, idx, pf),
                 table_read(1, (lb + m0 * DutySteps + d1) * TableSize, idx, pf), df);
        r1 = mix(table_read(1, (lb + m1 * DutySteps + d0) * TableSize, idx, pf),
                 table_read(1, (lb + m1 * DutySteps + d1) * TableSize, idx, pf), df);
        return 18'(mix(r0, r1, mf));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_shadow <= 1'b0;
            o_fail_count <= 0;
            o_pending <= 0;
            sample_q.delete();
        end else begin
            if (i_cfg_we) ready_shadow <= i_cfg_wdata;
            if (i_start && !i_busy) begin
                case (t_mode'(i_mode))
                    MODE_LOAD_SAW: begin
                        if (i_table_number < MorphSteps)
                            saw_shadow[(i_table_level * MorphSteps + i_table_number)
                                       * TableSize + i_sample_index] = i_sample_value;
                    end
                    MODE_LOAD_PULSE: begin
                        if (i_table_number < PulseTables)
                            pulse_shadow[(i_table_level * PulseTables + i_table_number)
                                         * TableSize + i_sample_index] = i_sample_value;
                    end
                    default: sample_q.push_back(predict_sample(t_mode'(i_mode), i_phase,
                        i_morph, i_duty, i_frequency_hz));
                endcase
            end
            if (i_valid) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected sample_out %0d", i_sample_out);
                    o_fail_count <= o_fail_count + 1;
                end else if (sample_q[0] !== i_sample_out) begin
                    $error("sample_out expected %0d actual %0d", sample_q[0], i_sample_out);
                    o_fail_count <= o_fail_count + 1;
                    void'(sample_q.pop_front());
                end else begin
                    void'(sample_q.pop_front());
                end
            end
            o_pending <= sample_q.size();
        end
    end
endmodule

// ===== test/tb_mipmap_wavetable_interp_lookup.sv =====
// top of the wavetable lookup testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_mipmap_wavetable_interp_lookup;
    import mwl_pkg::*;

    localparam int WatchLimit = 4000;
    localparam int RandomItems = 1950;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic [1:0]         i_mode;
    logic [31:0]        i_phase;
    logic [16:0]        i_morph;
    logic [16:0]        i_duty;
    logic [15:0]        i_frequency_hz;
    logic [2:0]         i_table_level;
    logic [7:0]         i_table_number;
    logic [11:0]        i_sample_index;
    logic signed [17:0] i_sample_value;
    logic               o_valid;
    logic signed [17:0] o_sample_out;

    int  fail_count;
    int  pending;
    int  quiet_cycles;
    int  item_count;
    logic busy_seen;     // o_busy as it stood before the coming edge
    bit  idle_on;
    bit  ready_now;
    bit  written[int];   // store entries loaded so far, keyed by kind and address

    mipmap_wavetable_interp_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .i_mode(i_mode),
        .i_phase(i_phase), .i_morph(i_morph), .i_duty(i_duty),
        .i_frequency_hz(i_frequency_hz), .i_table_level(i_table_level),
        .i_table_number(i_table_number), .i_sample_index(i_sample_index),
        .i_sample_value(i_sample_value), .o_valid(o_valid), .o_sample_out(o_sample_out)
    );

    mwl_lookup_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .i_mode(i_mode),
        .i_phase(i_phase), .i_morph(i_morph), .i_duty(i_duty),
        .i_frequency_hz(i_frequency_hz), .i_table_level(i_table_level),
        .i_table_number(i_table_number), .i_sample_index(i_sample_index),
        .i_sample_value(i_sample_value), .i_valid(o_valid), .i_sample_out(o_sample_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // busy only moves after a rising edge, so the falling edge sees its settled value
    always @(negedge i_clk) busy_seen <= o_busy;

    // watchdog: cycles with neither an item transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !busy_seen) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WatchLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // lower/upper step of a Q1.16 position, same split the block uses
    function automatic void step_pair(logic [16:0] pos, int steps, output int lo,
            output int hi);
        longint p;
        p = (pos > 17'd65536) ? 65536 : pos;
        lo = int'((p * (steps - 1)) >> 16);
        hi = (lo + 1 < steps) ? lo + 1 : steps - 1;
    endfunction

    function automatic int mip_level(logic [15:0] fr);
        int l;
        l = 0;
        while (l < MipLevels - 1 && fr >= (6000 << l)) l++;
        return l;
    endfunction

    task automatic put_item(t_mode m, logic [31:0] ph, logic [16:0] mo, logic [16:0] du,
            logic [15:0] fr, logic [2:0] lv, logic [7:0] tn, logic [11:0] si,
            logic [17:0] sv);
        if (idle_on) begin
            while ($urandom_range(99) < 31) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_mode <= m;
        i_phase <= ph;
        i_morph <= mo;
        i_duty <= du;
        i_frequency_hz <= fr;
        i_table_level <= lv;
        i_table_number <= tn;
        i_sample_index <= si;
        i_sample_value <= sv;
        do @(posedge i_clk); while (busy_seen);
        item_count++;
    endtask

    // one sample into a table; tab is level * 256 + table number
    task automatic load_sample(bit is_pulse, int tab, int idx);
        written[(int'(is_pulse) << 23) + tab * TableSize + idx] = 1'b1;
        put_item(is_pulse ? MODE_LOAD_PULSE : MODE_LOAD_SAW, $urandom, 17'($urandom),
                 17'($urandom), 16'($urandom), 3'(tab / 256), 8'(tab % 256), 12'(idx),
                 18'($urandom_range(0, 18'h3FFFF)));
    endtask

    // a lookup preceded, when tables are ready, by loads of every entry it will read
    // that is not yet filled, plus some random refreshes of filled ones
    task automatic lookup(t_mode m, logic [31:0] ph, logic [16:0] mo, logic [16:0] du,
            logic [15:0] fr);
        int tabs[$];
        int lvl, m0, m1, d0, d1, idx, a;
        bit pul;
        pul = (m == MODE_PULSE);
        if (ready_now) begin
            lvl = mip_level(fr);
            idx = ph[31:20];
            if (!pul) begin
                step_pair(mo, MorphSteps, m0, m1);
                tabs = '{lvl * 256 + m0, lvl * 256 + m1};
            end else begin
                step_pair(mo, PulseMorph, m0, m1);
                step_pair(du, DutySteps, d0, d1);
                tabs = '{lvl * 256 + m0 * DutySteps + d0, lvl * 256 + m0 * DutySteps + d1,
                         lvl * 256 + m1 * DutySteps + d0, lvl * 256 + m1 * DutySteps + d1};
            end
            foreach (tabs[t]) begin
                for (int k = 0; k < 2; k++) begin
                    a = (idx + k) % TableSize;
                    if (!written.exists((int'(pul) << 23) + tabs[t] * TableSize + a) ||
                        $urandom_range(3) == 0)
                        load_sample(pul, tabs[t], a);
                end
            end
        end
        put_item(m, ph, mo, du, fr, 3'($urandom), 8'($urandom), 12'($urandom),
                 18'($urandom));
    endtask

    // tables_ready changes only with the pipeline drained
    task automatic set_ready(bit v);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ready_now = v;
    endtask

    function automatic logic [16:0] rand_pos();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 17'h1FFFF));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [15:0] rand_freq();
        if ($urandom_range(1)) return 16'($urandom_range(0, 12000));
        return 16'($urandom);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_mode = MODE_LOAD_SAW;
        i_phase = '0;
        i_morph = '0;
        i_duty = '0;
        i_frequency_hz = '0;
        i_table_level = '0;
        i_table_number = '0;
        i_sample_index = '0;
        i_sample_value = '0;
        idle_on = 1'b1;
        ready_now = 1'b0;
        item_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tables not ready: every lookup answers zero, whatever it points at
        lookup(MODE_SAW, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
        lookup(MODE_PULSE, 32'h0, 17'd0, 17'd0, 16'd0);
        lookup(MODE_PULSE, $urandom, rand_pos(), rand_pos(), rand_freq());
        set_ready(1'b1);

        // directed corners: phase wrap at table end, positions at and above one,
        // mip thresholds, lowest and highest steps
        lookup(MODE_SAW, 32'h0, 17'd0, 17'd0, 16'd0);
        lookup(MODE_SAW, 32'hFFFF_FFFF, 17'd65536, 17'd0, 16'd5999);
        lookup(MODE_SAW, 32'hFFF0_0000, 17'h1FFFF, 17'd0, 16'd6000);
        lookup(MODE_SAW, 32'h8000_8000, 17'd32768, 17'd0, 16'hFFFF);
        lookup(MODE_PULSE, 32'h0, 17'd0, 17'd0, 16'd11999);
        lookup(MODE_PULSE, 32'hFFFF_FFFF, 17'd65536, 17'd65536, 16'd12000);
        lookup(MODE_PULSE, 32'hFFFF_FFF0, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
        lookup(MODE_PULSE, 32'h7FFF_FFFF, 17'd65535, 17'd1, 16'd48000);

        // random run: mostly loaded lookups, some stray loads, a quiet-free stretch,
        // and a spell with tables marked not ready
        while (item_count < RandomItems) begin
            idle_on = !(item_count > 700 && item_count < 1000);
            if (item_count > 1300 && item_count < 1400 && ready_now) set_ready(1'b0);
            if (item_count >= 1400 && !ready_now) set_ready(1'b1);
            if ($urandom_range(99) < 12)
                load_sample(1'($urandom_range(1)), $urandom_range(0, 2047),
                            $urandom_range(0, TableSize - 1));
            else
                lookup($urandom_range(1) ? MODE_PULSE : MODE_SAW, $urandom, rand_pos(),
                       rand_pos(), rand_freq());
        end
        set_ready(1'b0);
        lookup(MODE_SAW, $urandom, rand_pos(), rand_pos(), rand_freq());

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
